@@ sv/rcl_pkg.sv @@
// shared types and constants for the range image cluster labeling block
// no dependencies; used by the top module of the block by scoped names
`default_nettype none

package rcl_pkg;

    // payload field widths
    localparam int unsigned INDEX_W = 15;
    localparam int unsigned RANGE_W = 16;
    localparam int unsigned COUNT_W = 15;
    localparam int unsigned LABEL_W = 16;
    localparam int unsigned THR_W   = 16;

    // command kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // result kinds
    localparam logic RES_FRAME = 1'b0;
    localparam logic RES_READ  = 1'b1;

    // label of a cell that belongs to no cluster
    localparam logic signed [LABEL_W-1:0] NO_LABEL = '1;

    // join threshold after reset, millimetres
    localparam logic [THR_W-1:0] THR_RESET = 16'd600;

    // neighbor visiting order
    typedef logic [2:0] t_nb;
    localparam t_nb NB_LEFT  = 3'd0;
    localparam t_nb NB_RIGHT = 3'd1;
    localparam t_nb NB_UP    = 3'd2;
    localparam t_nb NB_DOWN  = 3'd3;
    localparam t_nb NB_END   = 3'd4;

    // input word
    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] cell_index;
        logic               cell_valid;
        logic [RANGE_W-1:0] cell_range;
        logic               last_cell;
    } t_cmd;

    // result word
    typedef struct packed {
        logic                      result_kind;
        logic [COUNT_W-1:0]        cluster_count;
        logic signed [LABEL_W-1:0] cell_label;
    } t_result;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED_RD,
        S_SEED_CHK,
        S_POP,
        S_FILL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ sv/range_image_cluster_labeling_top.sv @@
// range image cluster labeling: cell store, label store, fill queue and sequencer
// depends on rcl_pkg and rcl_ram
//
// usage
//   command channel: a word (i_cmd) is taken at a clock edge with start high and
//   busy low. a load word writes one cell (valid flag, range). a load
//   word with last_cell set also starts labeling of the frame; busy stays high
//   until the cycle in which the frame result word is shown.
//   a read word returns the label of one cell; its result shows up in the cycle
//   after the read is taken, and reads may follow each other in every cycle.
//   result channel: o_strobe marks a result word on o_result for one cycle; the
//   receiver takes it in that cycle and cannot hold it off.
//   config: i_cfg_we writes the join threshold; write only while idle.
//   labeling steps: a pass that clears the label store, then a seed scan over
//   the cells; each cell that joins a cluster takes one queue pop and the four
//   neighbor read/check steps through the label and cell memories; a step closes
//   each cluster, and a last step gives the frame result.
//   reset: the label store is cleared in a pass over every cell with busy
//   high; the threshold returns to 600 and the cluster count to zero.
`default_nettype none

module range_image_cluster_labeling_top #(
    parameter int unsigned RINGS      = 32,
    parameter int unsigned COLUMNS    = 900,
    parameter int unsigned RANGE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire rcl_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [rcl_pkg::THR_W-1:0]     i_cfg_wdata,
    output      logic                          o_strobe,
    output      rcl_pkg::t_result              o_result
);

    localparam int unsigned CELLS = RINGS * COLUMNS;
    localparam int unsigned IW    = $clog2(CELLS);
    localparam int unsigned CW    = $clog2(CELLS + 1);
    localparam int unsigned RBW   = $clog2(RINGS);
    localparam int unsigned CBW   = $clog2(COLUMNS);
    localparam int unsigned RW    = (RANGE_BITS < rcl_pkg::RANGE_W) ? RANGE_BITS
                                                                    : rcl_pkg::RANGE_W;
    localparam int unsigned LOW   = (CW < rcl_pkg::LABEL_W) ? CW : rcl_pkg::LABEL_W;
    localparam int unsigned RANGE_MAX = (1 << RW) - 1;

    // cell position carried through the fill
    typedef struct packed {
        logic [IW-1:0]  idx;
        logic [RBW-1:0] ring;
        logic [CBW-1:0] col;
    } t_pos;

    typedef struct packed {
        t_pos          pos;
        logic [RW-1:0] rng;
    } t_qent;

    typedef struct packed {
        logic          vld;
        logic [RW-1:0] rng;
    } t_cell;

    typedef struct packed {
        logic           has;
        logic [LOW-1:0] id;
    } t_lab;

    // registers
    rcl_pkg::t_state          r_state, n_state;
    logic [IW-1:0]            r_clr, n_clr;
    logic                     r_frame, n_frame;
    t_pos                     r_seed, n_seed;
    logic [CW-1:0]            r_id, n_id;
    logic [CW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_tail, n_tail;
    rcl_pkg::t_nb             r_k, n_k;
    t_pos                     r_nb, n_nb;
    logic                     r_nb_live, n_nb_live;
    logic [CW-1:0]            r_count, n_count;
    logic [rcl_pkg::THR_W-1:0] r_thr;
    logic                     r_rd_pend, n_rd_pend;
    logic                     r_rd_oob, n_rd_oob;
    logic                     r_done_pend, n_done_pend;

    // memory ports
    logic          cm_we, cm_re;
    logic [IW-1:0] cm_waddr, cm_raddr;
    t_cell         cm_wdata, cm_rdata;
    logic          lm_we, lm_re;
    logic [IW-1:0] lm_waddr, lm_raddr;
    t_lab          lm_wdata, lm_rdata;
    logic          qm_we, qm_re;
    logic [IW-1:0] qm_waddr, qm_raddr;
    t_qent         qm_wdata, qm_rdata;

    // cell store: valid flag and saturated range
    rcl_ram #(.WIDTH($bits(t_cell)), .DEPTH(CELLS)) u_cell_mem (
        .i_clk  (i_clk),
        .i_we   (cm_we),
        .i_waddr(cm_waddr),
        .i_wdata(cm_wdata),
        .i_re   (cm_re),
        .i_raddr(cm_raddr),
        .o_rdata(cm_rdata)
    );

    // label store
    rcl_ram #(.WIDTH($bits(t_lab)), .DEPTH(CELLS)) u_label_mem (
        .i_clk  (i_clk),
        .i_we   (lm_we),
        .i_waddr(lm_waddr),
        .i_wdata(lm_wdata),
        .i_re   (lm_re),
        .i_raddr(lm_raddr),
        .o_rdata(lm_rdata)
    );

    // breadth-first fill queue
    rcl_ram #(.WIDTH($bits(t_qent)), .DEPTH(CELLS)) u_queue_mem (
        .i_clk  (i_clk),
        .i_we   (qm_we),
        .i_waddr(qm_waddr),
        .i_wdata(qm_wdata),
        .i_re   (qm_re),
        .i_raddr(qm_raddr),
        .o_rdata(qm_rdata)
    );

    // command decode
    logic          cmd_in_range;
    logic [RW-1:0] cmd_rng_sat;
    logic          accept;

    assign busy         = (r_state != rcl_pkg::S_IDLE);
    assign accept       = start && !busy;
    assign cmd_in_range = (32'(i_cmd.cell_index) < CELLS);
    assign cmd_rng_sat  = (32'(i_cmd.cell_range) > RANGE_MAX) ? RW'(RANGE_MAX)
                                                             : RW'(i_cmd.cell_range);

    // neighbor of the cell at the queue head
    t_pos nb;
    logic nb_live;
    t_pos u_pos;

    assign u_pos = qm_rdata.pos;

    always_comb begin
        nb      = u_pos;
        nb_live = 1'b0;
        case (r_k)
            rcl_pkg::NB_LEFT: begin
                nb_live = 1'b1;
                if (u_pos.col == '0) begin
                    nb.col = CBW'(COLUMNS - 1);
                    nb.idx = u_pos.idx + IW'(COLUMNS - 1);
                end else begin
                    nb.col = u_pos.col - 1'b1;
                    nb.idx = u_pos.idx - 1'b1;
                end
            end
            rcl_pkg::NB_RIGHT: begin
                nb_live = 1'b1;
                if (u_pos.col == CBW'(COLUMNS - 1)) begin
                    nb.col = '0;
                    nb.idx = u_pos.idx - IW'(COLUMNS - 1);
                end else begin
                    nb.col = u_pos.col + 1'b1;
                    nb.idx = u_pos.idx + 1'b1;
                end
            end
            rcl_pkg::NB_UP: begin
                nb_live  = (u_pos.ring != '0);
                nb.ring  = u_pos.ring - 1'b1;
                nb.idx   = u_pos.idx - IW'(COLUMNS);
            end
            rcl_pkg::NB_DOWN: begin
                nb_live  = (u_pos.ring != RBW'(RINGS - 1));
                nb.ring  = u_pos.ring + 1'b1;
                nb.idx   = u_pos.idx + IW'(COLUMNS);
            end
            default: begin
                nb_live = 1'b0;
            end
        endcase
    end

    // join test between the head cell and the checked neighbor
    logic [RW-1:0] rng_diff;
    logic          nb_joins;

    assign rng_diff = (qm_rdata.rng > cm_rdata.rng) ? (qm_rdata.rng - cm_rdata.rng)
                                                     : (cm_rdata.rng - qm_rdata.rng);
    assign nb_joins = r_nb_live && cm_rdata.vld && !lm_rdata.has &&
                      (rcl_pkg::THR_W'(rng_diff) < r_thr);

    // next seed position in ring-major order
    t_pos seed_inc;
    logic seed_last;

    always_comb begin
        seed_inc     = r_seed;
        seed_inc.idx = r_seed.idx + 1'b1;
        if (r_seed.col == CBW'(COLUMNS - 1)) begin
            seed_inc.col  = '0;
            seed_inc.ring = r_seed.ring + 1'b1;
        end else begin
            seed_inc.col = r_seed.col + 1'b1;
        end
    end

    assign seed_last = (r_seed.idx == IW'(CELLS - 1));

    // sequencer: next state, memory accesses
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_frame     = r_frame;
        n_seed      = r_seed;
        n_id        = r_id;
        n_head      = r_head;
        n_tail      = r_tail;
        n_k         = r_k;
        n_nb        = r_nb;
        n_nb_live   = r_nb_live;
        n_count     = r_count;
        n_rd_pend   = 1'b0;
        n_rd_oob    = r_rd_oob;
        n_done_pend = 1'b0;

        cm_we    = 1'b0;
        cm_waddr = IW'(i_cmd.cell_index);
        cm_wdata = '{vld: i_cmd.cell_valid, rng: cmd_rng_sat};
        cm_re    = 1'b0;
        cm_raddr = r_seed.idx;
        lm_we    = 1'b0;
        lm_waddr = r_clr;
        lm_wdata = '{has: 1'b0, id: '0};
        lm_re    = 1'b0;
        lm_raddr = r_seed.idx;
        qm_we    = 1'b0;
        qm_waddr = r_tail[IW-1:0];
        qm_wdata = '{pos: r_nb, rng: cm_rdata.rng};
        qm_re    = 1'b0;
        qm_raddr = r_head[IW-1:0];

        case (r_state)
            rcl_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd.kind == rcl_pkg::KIND_READ) begin
                        lm_re     = cmd_in_range;
                        lm_raddr  = IW'(i_cmd.cell_index);
                        n_rd_pend = 1'b1;
                        n_rd_oob  = !cmd_in_range;
                    end else begin
                        cm_we = cmd_in_range;
                        if (i_cmd.last_cell) begin
                            n_state = rcl_pkg::S_CLEAR;
                            n_frame = 1'b1;
                            n_clr   = '0;
                        end
                    end
                end
            end
            // clearing pass over the label store
            rcl_pkg::S_CLEAR: begin
                lm_we = 1'b1;
                if (r_clr == IW'(CELLS - 1)) begin
                    n_clr  = '0;
                    n_seed = '{idx: '0, ring: '0, col: '0};
                    n_id   = '0;
                    if (r_frame) begin
                        n_state = rcl_pkg::S_SEED_RD;
                    end else begin
                        n_state = rcl_pkg::S_IDLE;
                    end
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            rcl_pkg::S_SEED_RD: begin
                cm_re   = 1'b1;
                lm_re   = 1'b1;
                n_state = rcl_pkg::S_SEED_CHK;
            end
            // start a new cluster from an unlabeled valid cell, or go on to the next seed
            rcl_pkg::S_SEED_CHK: begin
                if (cm_rdata.vld && !lm_rdata.has) begin
                    lm_we    = 1'b1;
                    lm_waddr = r_seed.idx;
                    lm_wdata = '{has: 1'b1, id: r_id[LOW-1:0]};
                    qm_we    = 1'b1;
                    qm_waddr = '0;
                    qm_wdata = '{pos: r_seed, rng: cm_rdata.rng};
                    n_head   = '0;
                    n_tail   = CW'(1);
                    n_state  = rcl_pkg::S_POP;
                end else if (seed_last) begin
                    n_state = rcl_pkg::S_DONE;
                end else begin
                    n_seed  = seed_inc;
                    n_state = rcl_pkg::S_SEED_RD;
                end
            end
            // take the next cell of the fill, or close the cluster
            rcl_pkg::S_POP: begin
                if (r_head == r_tail) begin
                    n_id = r_id + 1'b1;
                    if (seed_last) begin
                        n_state = rcl_pkg::S_DONE;
                    end else begin
                        n_seed  = seed_inc;
                        n_state = rcl_pkg::S_SEED_RD;
                    end
                end else begin
                    qm_re   = 1'b1;
                    n_head  = r_head + 1'b1;
                    n_k     = rcl_pkg::NB_LEFT;
                    n_state = rcl_pkg::S_FILL;
                end
            end
            // read neighbor k while checking neighbor k-1
            rcl_pkg::S_FILL: begin
                if (r_k != rcl_pkg::NB_END) begin
                    cm_re     = nb_live;
                    cm_raddr  = nb.idx;
                    lm_re     = nb_live;
                    lm_raddr  = nb.idx;
                    n_nb      = nb;
                    n_nb_live = nb_live;
                end
                if (r_k != rcl_pkg::NB_LEFT && nb_joins) begin
                    lm_we    = 1'b1;
                    lm_waddr = r_nb.idx;
                    lm_wdata = '{has: 1'b1, id: r_id[LOW-1:0]};
                    qm_we    = 1'b1;
                    n_tail   = r_tail + 1'b1;
                end
                if (r_k == rcl_pkg::NB_END) begin
                    n_state = rcl_pkg::S_POP;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            rcl_pkg::S_DONE: begin
                n_count     = r_id;
                n_done_pend = 1'b1;
                n_state     = rcl_pkg::S_IDLE;
            end
            default: begin
                n_state = rcl_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcl_pkg::S_CLEAR;
            r_clr       <= '0;
            r_frame     <= 1'b0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_done_pend <= 1'b0;
            r_k         <= rcl_pkg::NB_LEFT;
            r_nb_live   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_frame     <= n_frame;
            r_count     <= n_count;
            r_rd_pend   <= n_rd_pend;
            r_done_pend <= n_done_pend;
            r_k         <= n_k;
            r_nb_live   <= n_nb_live;
        end
    end

    // working registers of the fill
    always_ff @(posedge i_clk) begin
        r_seed   <= n_seed;
        r_id     <= n_id;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_nb     <= n_nb;
        r_rd_oob <= n_rd_oob;
    end

    // join threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rcl_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // result word
    always_comb begin
        o_strobe               = r_rd_pend || r_done_pend;
        o_result.cluster_count = rcl_pkg::COUNT_W'(r_count);
        if (r_rd_pend) begin
            o_result.result_kind = rcl_pkg::RES_READ;
            if (r_rd_oob || !lm_rdata.has) begin
                o_result.cell_label = rcl_pkg::NO_LABEL;
            end else begin
                o_result.cell_label = rcl_pkg::LABEL_W'(lm_rdata.id);
            end
        end else begin
            o_result.result_kind = rcl_pkg::RES_FRAME;
            o_result.cell_label  = rcl_pkg::NO_LABEL;
        end
    end

endmodule

`default_nettype wire

@@ sv/rcl_ram.sv @@
// simple dual port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module rcl_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
